### rtl/core/utf8h_pkg.sv
// Shared types and constants for the UTF-8 encoder with string hash.
// No dependencies; used by every module of the block but the checker.
package utf8h_pkg;

  localparam logic [31:0] CODE_LIMIT = 32'h0011_0000;
  localparam logic [31:0] HASH_TAG   = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_BAD   = 2'd2
  } kind_t;

  // one classified request, as queued between front and back
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte
    kind_t           kind;
    logic            closes;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        last_of_item;
    logic        string_done;
    logic [31:0] string_hash;
    logic [31:0] string_length;
    logic        bad_code_point;
  } result_t;

endpackage

### rtl/core/utf8h_front.sv
// Front end: classifies an incoming code point and builds its UTF-8 bytes.
// Depends on utf8h_pkg.
module utf8h_front (
  input  logic [31:0]       code_point,
  input  logic              closes_string,
  input  logic              no_character,
  output logic              keep,
  output utf8h_pkg::entry_t entry
);

  always_comb begin
    entry          = '0;
    entry.closes   = closes_string;
    entry.kind     = utf8h_pkg::KIND_CHAR;
    keep           = 1'b1;
    if (no_character) begin
      entry.kind = utf8h_pkg::KIND_CLOSE;
      // no character and no close: nothing to emit
      keep       = closes_string;
    end else if (code_point >= utf8h_pkg::CODE_LIMIT) begin
      entry.kind = utf8h_pkg::KIND_BAD;
    end else if (code_point < 32'h0000_0080) begin
      entry.bytes[0] = {1'b0, code_point[6:0]};
      entry.last_idx = 2'd0;
    end else if (code_point < 32'h0000_0800) begin
      entry.bytes[0] = {3'b110, code_point[10:6]};
      entry.bytes[1] = {2'b10, code_point[5:0]};
      entry.last_idx = 2'd1;
    end else if (code_point < 32'h0001_0000) begin
      entry.bytes[0] = {4'b1110, code_point[15:12]};
      entry.bytes[1] = {2'b10, code_point[11:6]};
      entry.bytes[2] = {2'b10, code_point[5:0]};
      entry.last_idx = 2'd2;
    end else begin
      entry.bytes[0] = {5'b11110, code_point[20:18]};
      entry.bytes[1] = {2'b10, code_point[17:12]};
      entry.bytes[2] = {2'b10, code_point[11:6]};
      entry.bytes[3] = {2'b10, code_point[5:0]};
      entry.last_idx = 2'd3;
    end
  end

endmodule

### rtl/core/utf8h_queue.sv
// Small request queue between front and back ends.
// Depends on utf8h_pkg.
module utf8h_queue #(
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  utf8h_pkg::entry_t        push_data,
  input  logic                     pop,
  output utf8h_pkg::entry_t        head,
  output utf8h_pkg::queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utf8h_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_CNT);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/utf8h_back.sv
// Back end: emits one result per cycle unless stalled or idle, keeps
// hash and length, owns the output register. Depends on utf8h_pkg.
module utf8h_back (
  input  logic                     clk,
  input  logic                     rst,
  input  utf8h_pkg::entry_t        head,
  input  utf8h_pkg::queue_status_t status,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output utf8h_pkg::result_t       result
);

  logic [31:0] hash_running;
  logic [31:0] bytes_emitted;
  logic [1:0]  idx;
  logic        out_load;
  logic        fire;
  logic        is_last;
  logic        is_char;
  logic [7:0]  cur_byte;
  logic [31:0] hash_next;
  logic [31:0] bytes_emitted_next;
  logic        done;
  utf8h_pkg::result_t res_next;

  assign out_load = !out_valid || !out_stall;
  assign fire     = out_load && !status.empty;
  assign is_char  = (head.kind == utf8h_pkg::KIND_CHAR);
  assign is_last  = !is_char || (idx == head.last_idx);
  assign cur_byte = head.bytes[idx];
  assign pop      = fire && is_last;

  always_comb begin
    hash_next          = hash_running;
    bytes_emitted_next = bytes_emitted;
    if (is_char) begin
      // hash * 31 + byte
      hash_next          = (hash_running << 5) - hash_running + {24'b0, cur_byte};
      bytes_emitted_next = bytes_emitted + 32'd1;
    end
    done = is_last && head.closes &&
           (head.kind == utf8h_pkg::KIND_CHAR || head.kind == utf8h_pkg::KIND_CLOSE);

    res_next                = '0;
    res_next.out_byte       = is_char ? cur_byte : 8'd0;
    res_next.byte_present   = is_char;
    res_next.last_of_item   = is_last;
    res_next.string_done    = done;
    res_next.string_hash    = done ? (hash_next | utf8h_pkg::HASH_TAG) : 32'd0;
    res_next.string_length  = done ? bytes_emitted_next : 32'd0;
    res_next.bad_code_point = (head.kind == utf8h_pkg::KIND_BAD);
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      idx           <= '0;
      hash_running  <= '0;
      bytes_emitted <= '0;
    end else begin
      if (out_load) begin
        out_valid <= !status.empty;
      end
      if (fire) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
        if (done || head.kind == utf8h_pkg::KIND_BAD) begin
          // string closed or discarded
          hash_running  <= '0;
          bytes_emitted <= '0;
        end else begin
          hash_running  <= hash_next;
          bytes_emitted <= bytes_emitted_next;
        end
      end
    end
  end

endmodule

### rtl/core/utf8_encode_with_string_hash.sv
// UTF-8 encoder with running string hash, top level.
// Depends on utf8h_pkg, utf8h_front, utf8h_queue, utf8h_back.
//
// Input channel: in_valid / in_stall with code_point, closes_string and
// no_character. A request is taken on a rising edge with in_valid high and
// in_stall low. in_stall rises only when the request queue (QUEUE_DEPTH
// entries) is full.
// Output channel: out_valid / out_stall with one result per handshake: one
// UTF-8 byte, or a string-close or bad-code-point marker. The last result of
// a good closing request carries the hash (bit 31 set) and byte length.
// A request passes through the queue and the output register before its
// first result appears. The back end emits one result per cycle unless
// stalled or idle: one per UTF-8 byte (1 to 4) of a code point, one for
// a close-only or bad request, none with no character and no close.
// The front keeps taking requests while the queue has room.
// Reset clears the queue, the output valid flag, the hash and the length.
// While out_stall is high the result holds and the back end waits; the
// front keeps filling the queue until it is full.
module utf8_encode_with_string_hash #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] code_point,
  input  logic        closes_string,
  input  logic        no_character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_present,
  output logic        last_of_item,
  output logic        string_done,
  output logic [31:0] string_hash,
  output logic [31:0] string_length,
  output logic        bad_code_point
);

  logic                     keep;
  logic                     pop;
  utf8h_pkg::entry_t        entry;
  utf8h_pkg::entry_t        head;
  utf8h_pkg::queue_status_t status;
  utf8h_pkg::result_t       result;

  assign in_stall = status.full;

  utf8h_front u_front (
    .code_point    (code_point),
    .closes_string (closes_string),
    .no_character  (no_character),
    .keep          (keep),
    .entry         (entry)
  );

  utf8h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && keep),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  utf8h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_byte       = result.out_byte;
  assign byte_present   = result.byte_present;
  assign last_of_item   = result.last_of_item;
  assign string_done    = result.string_done;
  assign string_hash    = result.string_hash;
  assign string_length  = result.string_length;
  assign bad_code_point = result.bad_code_point;

endmodule

### rtl/core/utf8h_checker.sv
// Port-level checks for utf8_encode_with_string_hash, plus its bind.
// Depends only on the top level's ports.
module utf8h_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        byte_present,
  input logic        last_of_item,
  input logic        string_done,
  input logic [31:0] string_hash,
  input logic        bad_code_point
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(string_hash))
    else $error("stalled result changed");

  a_bad_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_code_point |-> last_of_item && !byte_present && !string_done)
    else $error("bad code point result malformed");

  a_done_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> last_of_item && string_hash[31])
    else $error("string close without last flag or hash tag");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_present |-> out_byte == 8'd0)
    else $error("byte field set without byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind utf8_encode_with_string_hash utf8h_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .byte_present   (byte_present),
  .last_of_item   (last_of_item),
  .string_done    (string_done),
  .string_hash    (string_hash),
  .bad_code_point (bad_code_point)
);
